// ----- hdl/rag_pkg.sv -----
`default_nettype none

package rag_pkg;

   // field widths fixed by the channel formats
   localparam int OPCODE_BITS  = 3;
   localparam int OPERAND_BITS = 32;
   localparam int NUM_OUT_BITS = 32;
   localparam int DEN_OUT_BITS = 31;
   localparam int CMP_BITS     = 2;
   localparam int ERR_BITS     = 2;

   // shift-add multiplier walks one operand bit per cycle
   localparam int MUL_STEPS = OPERAND_BITS;
   localparam int MCW       = $clog2(MUL_STEPS);

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_LOAD,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_CMP
   } opcode_type;

   typedef enum logic [CMP_BITS-1:0] {
      CMP_LESS,
      CMP_GREATER,
      CMP_EQUAL,
      CMP_NONE
   } cmp_type;

   typedef enum logic [ERR_BITS-1:0] {
      ERR_OK,
      ERR_ZERO,
      ERR_OVERFLOW
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_EVAL,
      ST_GCD,
      ST_DIV,
      ST_FIN,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic start;
      logic mul_step;
      logic eval;
      logic gcd_step;
      logic div_start;
      logic div_step;
      logic fin;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic need_reduce;
      logic gcd_done;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hdl/rag_req_if.sv -----
`default_nettype none

interface rag_req_if import rag_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic [OPCODE_BITS-1:0]         opcode;
   logic signed [OPERAND_BITS-1:0] operand;
   logic signed [OPERAND_BITS-1:0] load_denominator;

   modport source (output valid, output opcode, output operand, output load_denominator,
                   input ready);
   modport sink (input valid, input opcode, input operand, input load_denominator,
                 output ready);
endinterface

`default_nettype wire

// ----- hdl/rag_rsp_if.sv -----
`default_nettype none

interface rag_rsp_if import rag_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [NUM_OUT_BITS-1:0] numerator_out;
   logic [DEN_OUT_BITS-1:0]        denominator_out;
   logic [CMP_BITS-1:0]            compare_result;
   logic [ERR_BITS-1:0]            error_code;

   modport source (output valid, output numerator_out, output denominator_out,
                   output compare_result, output error_code, input ready);
   modport sink (input valid, input numerator_out, input denominator_out,
                 input compare_result, input error_code, output ready);
endinterface

`default_nettype wire

// ----- hdl/rag_ctrl.sv -----
`default_nettype none

module rag_ctrl import rag_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.need_reduce ? ST_GCD : ST_RESULT;
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/rag_dpath.sv -----
`default_nettype none

module rag_dpath import rag_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   input  logic [OPCODE_BITS-1:0]   req_opcode,
   input  logic [OPERAND_BITS-1:0]  req_operand,
   input  logic [OPERAND_BITS-1:0]  req_load_denominator,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [NUM_OUT_BITS-1:0]  rsp_numerator_out,
   output logic [DEN_OUT_BITS-1:0]  rsp_denominator_out,
   output logic [CMP_BITS-1:0]      rsp_compare_result,
   output logic [ERR_BITS-1:0]      rsp_error_code
);

   localparam int GW  = (WORD_BITS > OPERAND_BITS) ? WORD_BITS : OPERAND_BITS;
   localparam int PW  = GW + OPERAND_BITS;
   localparam int EW  = PW + 2;
   localparam int KW  = $clog2(GW);
   localparam int DCW = $clog2(GW);

   localparam logic [PW-1:0]        P_LIM_NEG = PW'(1) << (WORD_BITS - 1);
   localparam logic [PW-1:0]        P_LIM_POS = P_LIM_NEG - PW'(1);
   localparam logic [GW-1:0]        G_LIM_NEG = GW'(1) << (WORD_BITS - 1);
   localparam logic [GW-1:0]        G_LIM_POS = G_LIM_NEG - GW'(1);
   localparam logic signed [EW-1:0] S_MAX     = EW'(P_LIM_POS);
   localparam logic signed [EW-1:0] S_MIN     = -S_MAX - EW'(1);

   // fraction state
   logic [WORD_BITS-1:0]    num_ff;
   logic [WORD_BITS-1:0]    den_ff;

   // item registers
   logic [OPCODE_BITS-1:0]  op_ff;
   logic [OPERAND_BITS-1:0] x_ff;
   logic [OPERAND_BITS-1:0] y_ff;

   // multiplier
   logic [PW-1:0]           mcand_ff;
   logic [OPERAND_BITS-1:0] mplier_ff;
   logic [PW-1:0]           prod_ff;
   logic [MCW-1:0]          mcnt_ff;

   // gcd and divide
   logic [GW-1:0]           u_ff;
   logic [GW-1:0]           v_ff;
   logic [KW-1:0]           k_ff;
   logic [GW-1:0]           nm_ff;
   logic [GW-1:0]           dm_ff;
   logic                    neg_ff;
   logic [GW-1:0]           dvs_ff;
   logic [GW-1:0]           qn_ff;
   logic [GW-1:0]           qd_ff;
   logic [GW-1:0]           rn_ff;
   logic [GW-1:0]           rd_ff;
   logic [DCW-1:0]          dcnt_ff;

   // result and output
   cmp_type                 res_cmp_ff;
   err_type                 res_err_ff;
   logic                    rsp_valid_ff;
   logic [NUM_OUT_BITS-1:0] out_num_ff;
   logic [DEN_OUT_BITS-1:0] out_den_ff;
   cmp_type                 out_cmp_ff;
   err_type                 out_err_ff;

   // combinational
   logic [OPERAND_BITS-1:0] req_x_mag;
   logic [OPERAND_BITS-1:0] x_mag;
   logic [OPERAND_BITS-1:0] y_mag;
   logic [WORD_BITS-1:0]    a_mag;
   logic                    x_neg;
   logic                    y_neg;
   logic                    a_neg;
   logic                    uses_mul;
   logic [EW-1:0]           p_wide;
   logic signed [EW-1:0]    p_s;
   logic signed [EW-1:0]    a_s;
   logic signed [EW-1:0]    sum_s;
   logic signed [EW-1:0]    dif_s;
   logic                    p_ok;
   logic                    sum_ok;
   logic                    dif_ok;
   err_type                 ev_err;
   cmp_type                 ev_cmp;
   logic                    ev_reduce;
   logic                    ev_write;
   logic [WORD_BITS-1:0]    ev_num;
   logic [GW-1:0]           rd_nm;
   logic [GW-1:0]           rd_dm;
   logic                    rd_neg;
   logic [GW:0]             rn_sh;
   logic [GW:0]             rd_sh;
   logic                    rn_ge;
   logic                    rd_ge;
   logic [GW:0]             dvs_wide;
   logic                    fin_err;
   logic [WORD_BITS-1:0]    fin_num;
   logic [GW:0]             num_wide;
   logic [GW-1:0]           den_wide;

   assign req_x_mag = req_operand[OPERAND_BITS-1] ? ('0 - req_operand) : req_operand;
   assign x_neg     = x_ff[OPERAND_BITS-1];
   assign y_neg     = y_ff[OPERAND_BITS-1];
   assign a_neg     = num_ff[WORD_BITS-1];
   assign x_mag     = x_neg ? ('0 - x_ff) : x_ff;
   assign y_mag     = y_neg ? ('0 - y_ff) : y_ff;
   assign a_mag     = a_neg ? ('0 - num_ff) : num_ff;
   assign uses_mul  = (op_ff != OP_LOAD) && (op_ff <= OP_CMP);

   // signed product operand * denominator (add, subtract, compare) and its sums with the numerator
   always_comb begin
      p_wide = {2'b00, prod_ff};
      p_s    = x_neg ? (EW'(0) - p_wide) : p_wide;
      a_s    = EW'(signed'(num_ff));
      sum_s  = a_s + p_s;
      dif_s  = a_s - p_s;
      p_ok   = x_neg ? (prod_ff <= P_LIM_NEG) : (prod_ff <= P_LIM_POS);
      sum_ok = (sum_s >= S_MIN) && (sum_s <= S_MAX);
      dif_ok = (dif_s >= S_MIN) && (dif_s <= S_MAX);
   end

   always_comb begin
      ev_err    = ERR_OK;
      ev_cmp    = CMP_NONE;
      ev_reduce = 1'b0;
      ev_write  = 1'b0;
      ev_num    = sum_s[WORD_BITS-1:0];
      rd_nm     = GW'(x_mag);
      rd_dm     = GW'(y_mag);
      rd_neg    = x_neg ^ y_neg;
      case (op_ff)
         OP_LOAD: begin
            if (y_ff == '0) begin
               ev_err = ERR_ZERO;
            end else begin
               ev_reduce = 1'b1;
            end
         end
         OP_ADD: begin
            if (!p_ok || !sum_ok) begin
               ev_err = ERR_OVERFLOW;
            end else begin
               ev_write = 1'b1;
            end
         end
         OP_SUB: begin
            ev_num = dif_s[WORD_BITS-1:0];
            if (!p_ok || !dif_ok) begin
               ev_err = ERR_OVERFLOW;
            end else begin
               ev_write = 1'b1;
            end
         end
         OP_MUL: begin
            rd_nm  = prod_ff[GW-1:0];
            rd_dm  = GW'(den_ff);
            rd_neg = a_neg ^ x_neg;
            if (prod_ff > P_LIM_NEG) begin
               ev_err = ERR_OVERFLOW;
            end else begin
               ev_reduce = 1'b1;
            end
         end
         OP_DIV: begin
            rd_nm  = GW'(a_mag);
            rd_dm  = prod_ff[GW-1:0];
            rd_neg = a_neg ^ x_neg;
            if (x_ff == '0) begin
               ev_err = ERR_ZERO;
            end else if (prod_ff > P_LIM_NEG) begin
               ev_err = ERR_OVERFLOW;
            end else begin
               ev_reduce = 1'b1;
            end
         end
         OP_CMP: begin
            // denominator is positive, so a/b vs x is a vs x*b
            if (a_s < p_s) begin
               ev_cmp = CMP_LESS;
            end else if (a_s > p_s) begin
               ev_cmp = CMP_GREATER;
            end else begin
               ev_cmp = CMP_EQUAL;
            end
         end
         default: begin
         end
      endcase
   end

   // restoring divide step, same divisor for both quotients
   always_comb begin
      dvs_wide = {1'b0, dvs_ff};
      rn_sh    = {rn_ff, qn_ff[GW-1]};
      rd_sh    = {rd_ff, qd_ff[GW-1]};
      rn_ge    = rn_sh >= dvs_wide;
      rd_ge    = rd_sh >= dvs_wide;
   end

   assign fin_err = (qd_ff > G_LIM_POS) || (qn_ff > (neg_ff ? G_LIM_NEG : G_LIM_POS));
   assign fin_num = neg_ff ? ('0 - qn_ff[WORD_BITS-1:0]) : qn_ff[WORD_BITS-1:0];

   assign num_wide = (GW + 1)'(signed'(num_ff));
   assign den_wide = GW'(den_ff);

   assign status.mul_done    = (mcnt_ff == MCW'(MUL_STEPS - 1)) || !uses_mul;
   assign status.need_reduce = ev_reduce;
   assign status.gcd_done    = (u_ff == '0);
   assign status.div_done    = (dcnt_ff == DCW'(GW - 1));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   // fraction state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= '0;
         den_ff       <= WORD_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.eval && ev_write) begin
            num_ff <= ev_num;
         end
         if (cmd.fin && !fin_err) begin
            num_ff <= fin_num;
            den_ff <= qd_ff[WORD_BITS-1:0];
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= req_opcode;
         x_ff      <= req_operand;
         y_ff      <= req_load_denominator;
         mcand_ff  <= (req_opcode == OP_MUL) ? PW'(a_mag) : PW'(den_ff);
         mplier_ff <= req_x_mag;
         prod_ff   <= '0;
         mcnt_ff   <= '0;
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_ff <= prod_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         mcnt_ff   <= mcnt_ff + MCW'(1);
      end

      if (cmd.eval) begin
         res_err_ff <= ev_err;
         res_cmp_ff <= ev_cmp;
         u_ff       <= rd_nm;
         v_ff       <= rd_dm;
         k_ff       <= '0;
         nm_ff      <= rd_nm;
         dm_ff      <= rd_dm;
         neg_ff     <= rd_neg;
      end else if (cmd.gcd_step) begin
         // binary gcd: strip common twos, then odd parts by shift and subtract
         if (!u_ff[0] && !v_ff[0]) begin
            u_ff <= u_ff >> 1;
            v_ff <= v_ff >> 1;
            k_ff <= k_ff + KW'(1);
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_ff <= u_ff - v_ff;
         end else begin
            v_ff <= v_ff - u_ff;
         end
      end

      if (cmd.div_start) begin
         dvs_ff  <= v_ff << k_ff;
         qn_ff   <= nm_ff;
         qd_ff   <= dm_ff;
         rn_ff   <= '0;
         rd_ff   <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rn_ff   <= rn_ge ? GW'(rn_sh - dvs_wide) : rn_sh[GW-1:0];
         rd_ff   <= rd_ge ? GW'(rd_sh - dvs_wide) : rd_sh[GW-1:0];
         qn_ff   <= {qn_ff[GW-2:0], rn_ge};
         qd_ff   <= {qd_ff[GW-2:0], rd_ge};
         dcnt_ff <= dcnt_ff + DCW'(1);
      end

      if (cmd.fin) begin
         res_err_ff <= fin_err ? ERR_OVERFLOW : ERR_OK;
         res_cmp_ff <= CMP_NONE;
      end

      // the result always shows the fraction as it now stands
      if (cmd.emit) begin
         out_num_ff <= num_wide[NUM_OUT_BITS-1:0];
         out_den_ff <= den_wide[DEN_OUT_BITS-1:0];
         out_cmp_ff <= res_cmp_ff;
         out_err_ff <= res_err_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_numerator_out   = out_num_ff;
   assign rsp_denominator_out = out_den_ff;
   assign rsp_compare_result  = out_cmp_ff;
   assign rsp_error_code      = out_err_ff;

endmodule

`default_nettype wire

// ----- hdl/rational_accumulator_gcd_reduce.sv -----
`default_nettype none

// Rational accumulator: holds one fraction in lowest terms, signed numerator over a
// positive denominator, both WORD_BITS wide (reset 0/1). Each request beat carries an
// opcode (load, add, subtract, multiply, divide, compare) and 32-bit operands; each
// request produces exactly one response beat showing the fraction after the step,
// a compare code and an error code (zero divisor or denominator, or overflow; on
// error the fraction is left as it was). One request is worked at a time. Steps:
// accept, the shift-add multiplier (which does no work for load and unused opcodes),
// evaluate and post the response; add, subtract and compare end there, as do unused
// opcodes and any request that hits an error at evaluate.
// Load, multiply and divide then reduce the fraction: a binary gcd doing one shift
// or subtract per cycle, a restoring divider producing both reduced terms at one bit
// per cycle and a commit step. A response stall holds the finished request in the
// post state until the output register is free.
// The response sits in an output register, so the next request is taken while a
// finished beat waits.

module rational_accumulator_gcd_reduce import rag_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   rag_req_if.sink   req_if,
   rag_rsp_if.source rsp_if
);

   // command and status between sequencer and datapath
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: accept, multiply, evaluate, gcd, divide, finish, post result
   rag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: fraction state, multiplier, gcd, divider and output register
   rag_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_opcode           (req_if.opcode),
      .req_operand          (req_if.operand),
      .req_load_denominator (req_if.load_denominator),
      .rsp_ready            (rsp_if.ready),
      .rsp_valid            (rsp_if.valid),
      .rsp_numerator_out    (rsp_if.numerator_out),
      .rsp_denominator_out  (rsp_if.denominator_out),
      .rsp_compare_result   (rsp_if.compare_result),
      .rsp_error_code       (rsp_if.error_code)
   );

endmodule

`default_nettype wire

// ----- verif/rational_accumulator_gcd_reduce_tb.sv -----
module rational_accumulator_gcd_reduce_tb;
   import rag_pkg::*;

   // run sizing
   localparam int RANDOM_PER_PHASE = 300;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int DRAIN_CYCLES     = 200;
   localparam int HOLD_OFF_CYCLES  = 400;   // long response stall, fills the block

   // word limits at WORD_BITS = 32
   localparam longint          WORD_HI = 64'sh7FFF_FFFF;
   localparam longint          WORD_LO = -64'sh8000_0000;
   localparam longint unsigned MAG_HI  = 64'h7FFF_FFFF;
   localparam longint unsigned MAG_NEG = 64'h8000_0000;
   localparam int              I32_MAX = 32'h7FFF_FFFF;
   localparam int              I32_MIN = 32'h8000_0000;

   // opcodes the block leaves alone
   localparam logic [OPCODE_BITS-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPCODE_BITS-1:0] OP_SPARE_HI = 3'd7;

   // directed rows either carry a hand-written result or lean on the predictor
   localparam bit TYPED   = 1'b1;
   localparam bit PREDICT = 1'b0;

   typedef struct {
      logic signed [NUM_OUT_BITS-1:0] num;
      logic [DEN_OUT_BITS-1:0]        den;
      cmp_type                        cmp;
      err_type                        err;
   } fraction_beat_type;

   typedef struct {
      logic [OPCODE_BITS-1:0] op;
      int                     operand;
      int                     load_den;
      bit                     typed;
      fraction_beat_type      want;
   } stim_row_type;

   logic clock;
   logic reset;

   rag_req_if req_ch ();
   rag_rsp_if rsp_ch ();

   rational_accumulator_gcd_reduce #(.WORD_BITS(32)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predicted fraction, kept in 64 bits so the range checks never wrap
   longint frac_num;
   longint frac_den;

   fraction_beat_type pending_fractions[$];
   stim_row_type      directed_rows[$];

   int fail_count;
   int cycle_count;
   int send_idle_pct;
   int rcv_idle_pct;
   bit hold_off_armed;

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   function automatic longint unsigned magnitude_of(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint apply_sign(input bit neg, input longint unsigned m);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned euclid_gcd(input longint unsigned p,
                                                  input longint unsigned q);
      longint unsigned rem;
      while (q != 0) begin
         rem = p % q;
         p   = q;
         q   = rem;
      end
      return p;
   endfunction

   // signed product that must land inside the word
   function automatic bit signed_product(input longint p, input longint q,
                                         output longint prod);
      longint unsigned mp, mq, lim;
      bit              neg;
      mp   = magnitude_of(p);
      mq   = magnitude_of(q);
      neg  = (p < 0) != (q < 0);
      lim  = neg ? MAG_NEG : MAG_HI;
      prod = 0;
      if (mp != 0 && mq > lim / mp) return 1'b0;
      prod = apply_sign(neg, mp * mq);
      return 1'b1;
   endfunction

   // magnitude product, capped at the negative limit before reduction
   function automatic bit magnitude_product(input longint unsigned p, input longint unsigned q,
                                            output longint unsigned prod);
      prod = 0;
      if (p != 0 && q > MAG_NEG / p) return 1'b0;
      prod = p * q;
      return 1'b1;
   endfunction

   // divide out the gcd, range check, and commit only when both terms fit
   function automatic err_type reduce_into_fraction(input bit neg, input longint unsigned nm,
                                                    input longint unsigned dm);
      longint unsigned g;
      g  = euclid_gcd(nm, dm);
      nm = nm / g;
      dm = dm / g;
      if (dm > MAG_HI) return ERR_OVERFLOW;
      if (nm > (neg ? MAG_NEG : MAG_HI)) return ERR_OVERFLOW;
      frac_num = apply_sign(neg, nm);
      frac_den = longint'(dm);
      return ERR_OK;
   endfunction

   function automatic fraction_beat_type step_fraction(input logic [OPCODE_BITS-1:0] op,
                                                       input int x_in, input int y_in);
      longint            x, y, a, b, t, q, r;
      longint unsigned   m;
      fraction_beat_type res;
      x = x_in;
      y = y_in;
      a = frac_num;
      b = frac_den;
      res.cmp = CMP_NONE;
      res.err = ERR_OK;
      case (op)
         OP_LOAD: begin
            if (y == 0) res.err = ERR_ZERO;
            else res.err = reduce_into_fraction((x < 0) != (y < 0), magnitude_of(x),
                                                magnitude_of(y));
         end
         OP_ADD: begin
            // numerator plus operand * denominator stays coprime with the denominator, no reduce
            if (!signed_product(x, b, t)) res.err = ERR_OVERFLOW;
            else if ((t > 0 && a > WORD_HI - t) || (t < 0 && a < WORD_LO - t))
               res.err = ERR_OVERFLOW;
            else frac_num = a + t;
         end
         OP_SUB: begin
            if (!signed_product(x, b, t)) res.err = ERR_OVERFLOW;
            else if ((t < 0 && a > WORD_HI + t) || (t > 0 && a < WORD_LO + t))
               res.err = ERR_OVERFLOW;
            else frac_num = a - t;
         end
         OP_MUL: begin
            if (!magnitude_product(magnitude_of(a), magnitude_of(x), m)) res.err = ERR_OVERFLOW;
            else res.err = reduce_into_fraction((a < 0) != (x < 0), m, longint'(b));
         end
         OP_DIV: begin
            if (x == 0) res.err = ERR_ZERO;
            else if (!magnitude_product(longint'(b), magnitude_of(x), m))
               res.err = ERR_OVERFLOW;
            else res.err = reduce_into_fraction((a < 0) != (x < 0), magnitude_of(a), m);
         end
         OP_CMP: begin
            // floor quotient and non-negative remainder give an exact compare
            q = a / b;
            r = a % b;
            if (r < 0) begin
               q = q - 1;
               r = r + b;
            end
            if (x > q) res.cmp = CMP_LESS;
            else if (x < q) res.cmp = CMP_GREATER;
            else res.cmp = (r == 0) ? CMP_EQUAL : CMP_GREATER;
         end
         default: ;
      endcase
      res.num = frac_num[NUM_OUT_BITS-1:0];
      res.den = frac_den[DEN_OUT_BITS-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   task automatic add_row(input logic [OPCODE_BITS-1:0] op, input int x, input int y,
                          input bit typed = PREDICT, input int num = 0, input int den = 0,
                          input cmp_type cmp = CMP_NONE, input err_type err = ERR_OK);
      stim_row_type row;
      row.op        = op;
      row.operand   = x;
      row.load_den  = y;
      row.typed     = typed;
      row.want.num  = num;
      row.want.den  = den[DEN_OUT_BITS-1:0];
      row.want.cmp  = cmp;
      row.want.err  = err;
      directed_rows.push_back(row);
   endtask

   // mostly small values so fractions stay alive across many steps
   function automatic int pick_operand();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return int'($urandom_range(0, 40)) - 20;
         5, 6:          return int'($urandom_range(0, 2000)) - 1000;
         7:             return $urandom;
         8: begin
            case ($urandom_range(0, 4))
               0:       return I32_MIN;
               1:       return I32_MAX;
               2:       return 0;
               3:       return 1;
               default: return -1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1)) return 1 << $urandom_range(0, 30);
            return -(1 << $urandom_range(0, 31));
         end
      endcase
   endfunction

   function automatic logic [OPCODE_BITS-1:0] pick_opcode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 18) return OP_LOAD;
      if (roll < 33) return OP_ADD;
      if (roll < 46) return OP_SUB;
      if (roll < 62) return OP_MUL;
      if (roll < 78) return OP_DIV;
      if (roll < 95) return OP_CMP;
      return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
   endfunction

   // offer one request beat and return at the edge that takes it;
   // valid is left high so back-to-back beats need no second write in one step
   task automatic drive_request(input logic [OPCODE_BITS-1:0] op, input int x, input int y);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap != 0) begin
         // junk payload while idle, the block must ignore it
         req_ch.valid            <= 1'b0;
         req_ch.opcode           <= OPCODE_BITS'($urandom);
         req_ch.operand          <= $urandom;
         req_ch.load_denominator <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.opcode           <= op;
      req_ch.operand          <= x;
      req_ch.load_denominator <= y;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic report_mismatch(input string field, input longint want, input longint got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // ---------------------------------------------------------------------------
   // clock, watchdog
   // ---------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // response side: random back-pressure plus one long hold-off
   // ---------------------------------------------------------------------------

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_armed) begin
            // sender keeps offering, so the block fills and drops req ready
            hold_off_armed = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // every accepted response beat is matched against the oldest prediction
   always @(posedge clock) begin
      fraction_beat_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_fractions.size() == 0) begin
            fail_count++;
            $display("%0t: response beat with nothing expected, actual %0d/%0d", $time,
                     rsp_ch.numerator_out, rsp_ch.denominator_out);
         end else begin
            want = pending_fractions.pop_front();
            if (rsp_ch.numerator_out !== want.num)
               report_mismatch("numerator", want.num, rsp_ch.numerator_out);
            if (rsp_ch.denominator_out !== want.den)
               report_mismatch("denominator", want.den, rsp_ch.denominator_out);
            if (rsp_ch.compare_result !== want.cmp)
               report_mismatch("compare", want.cmp, rsp_ch.compare_result);
            if (rsp_ch.error_code !== want.err)
               report_mismatch("error", want.err, rsp_ch.error_code);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // request side: directed table, then three idle phases of random beats
   // ---------------------------------------------------------------------------

   initial begin
      logic [OPCODE_BITS-1:0] op;
      int                     x, y;
      fraction_beat_type      want;
      int                     send_pct[3];
      int                     rcv_pct[3];

      send_pct = '{36, 70, 0};
      rcv_pct  = '{70, 36, 0};

      fail_count              = 0;
      cycle_count             = 0;
      hold_off_armed          = 1'b0;
      send_idle_pct           = send_pct[0];
      rcv_idle_pct            = rcv_pct[0];
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.opcode           = OP_LOAD;
      req_ch.operand          = 0;
      req_ch.load_denominator = 1;
      frac_num                = 0;
      frac_den                = 1;

      // fresh fraction is 0/1
      add_row(OP_CMP,  0,       0,       TYPED, 0,       1, CMP_EQUAL);
      // sign moves to the numerator, gcd taken on magnitudes
      add_row(OP_LOAD, 6,       -4,      TYPED, -3,      2);
      // zero denominator and zero divisor leave the fraction alone
      add_row(OP_LOAD, 5,       0,       TYPED, -3,      2, CMP_NONE, ERR_ZERO);
      add_row(OP_DIV,  0,       0,       TYPED, -3,      2, CMP_NONE, ERR_ZERO);
      // most negative numerator fits, its negation does not
      add_row(OP_LOAD, I32_MIN, 1,       TYPED, I32_MIN, 1);
      add_row(OP_LOAD, I32_MIN, -1,      TYPED, I32_MIN, 1, CMP_NONE, ERR_OVERFLOW);
      add_row(OP_ADD,  1,       0,       TYPED, I32_MIN + 1, 1);
      // sum or difference out of the word
      add_row(OP_SUB,  2,       0,       TYPED, I32_MIN + 1, 1, CMP_NONE, ERR_OVERFLOW);
      add_row(OP_MUL,  -1,      0,       TYPED, I32_MAX, 1);
      add_row(OP_ADD,  1,       0,       TYPED, I32_MAX, 1, CMP_NONE, ERR_OVERFLOW);
      // denominator of 2^31 does not fit
      add_row(OP_LOAD, I32_MAX, I32_MIN, TYPED, I32_MAX, 1, CMP_NONE, ERR_OVERFLOW);
      add_row(OP_LOAD, 7,       3,       TYPED, 7,       3);
      // exact compare against 7/3
      add_row(OP_CMP,  2,       0,       TYPED, 7,       3, CMP_GREATER);
      add_row(OP_CMP,  3,       0,       TYPED, 7,       3, CMP_LESS);
      add_row(OP_CMP,  I32_MIN, 0,       TYPED, 7,       3, CMP_GREATER);
      // unused opcodes do nothing
      add_row(OP_SPARE_LO, 9,   9,       TYPED, 7,       3);
      add_row(OP_SPARE_HI, -9,  -9,      TYPED, 7,       3);
      add_row(OP_DIV,  -7,      0);
      add_row(OP_MUL,  6,       0);
      add_row(OP_LOAD, -1,      I32_MIN);
      add_row(OP_LOAD, 0,       -5,      TYPED, 0,       1);
      // product fits but the difference does not
      add_row(OP_SUB,  I32_MIN, 0);
      add_row(OP_CMP,  -1,      0);
      add_row(OP_LOAD, I32_MAX, I32_MAX, TYPED, 1,       1);
      add_row(OP_DIV,  I32_MIN, 0);
      add_row(OP_MUL,  I32_MIN, 0);
      add_row(OP_DIV,  -1,      0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         drive_request(directed_rows[i].op, directed_rows[i].operand,
                       directed_rows[i].load_den);
         want = step_fraction(directed_rows[i].op, directed_rows[i].operand,
                              directed_rows[i].load_den);
         if (directed_rows[i].typed) want = directed_rows[i].want;
         pending_fractions.push_back(want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pct[phase];
         rcv_idle_pct  = rcv_pct[phase];
         // the no-idle phase starts with the long response stall
         if (phase == 2) hold_off_armed = 1'b1;
         repeat (RANDOM_PER_PHASE) begin
            op = pick_opcode();
            x  = pick_operand();
            y  = pick_operand();
            drive_request(op, x, y);
            pending_fractions.push_back(step_fraction(op, x, y));
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/rag_pkg.sv
hdl/rag_req_if.sv
hdl/rag_rsp_if.sv
hdl/rag_ctrl.sv
hdl/rag_dpath.sv
hdl/rational_accumulator_gcd_reduce.sv
verif/rational_accumulator_gcd_reduce_tb.sv
